>>> sv/ulbp_pkg.sv
package ulbp_pkg;

    localparam int CODE_W      = 8;
    localparam int LABEL_W     = 8;
    localparam int CNT_W       = 4;
    localparam int STEP_W      = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int TABLE_DEPTH = 256;

    localparam logic [CODE_W-1:0] CODE_LAST = 8'hFF;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

    localparam logic OP_BUILD  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRANSITIONS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_INVARIANT = 1'd1;

    typedef struct packed {
        logic              operation;
        logic [CODE_W-1:0] code;
    } in_word_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] null_label;
        logic               table_valid;
    } out_word_t;

    // Status of the rotate and compare unit toward the sequencer.
    typedef struct packed {
        logic              done;
        logic [CNT_W-1:0]  trans_cnt;
        logic [CODE_W-1:0] min_rot;
    } rot_status_t;

endpackage

>>> sv/ulbp_rot_unit.sv
module ulbp_rot_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ulbp_pkg::CODE_W-1:0]   code_in,
    output ulbp_pkg::rot_status_t         status
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ulbp_pkg::STEP_W-1:0]   step_reg;
    logic [ulbp_pkg::CODE_W-1:0]   rot_reg;
    logic [ulbp_pkg::CODE_W-1:0]   best_reg;
    logic [ulbp_pkg::CNT_W-1:0]    cnt_reg;
    logic [ulbp_pkg::CODE_W-1:0]   rot_next;

    // One step rotates right by one, counts the transition between the two
    // low bits and keeps the smaller of the running minimum and the rotation.
    assign rot_next = {rot_reg[0], rot_reg[ulbp_pkg::CODE_W-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == ulbp_pkg::STEP_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == ulbp_pkg::STEP_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rot_reg  <= code_in;
            best_reg <= code_in;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            rot_reg <= rot_next;
            cnt_reg <= cnt_reg + {{(ulbp_pkg::CNT_W-1){1'b0}}, rot_reg[0] ^ rot_reg[1]};
            if (rot_next < best_reg) begin
                best_reg <= rot_next;
            end
        end
    end

    assign status.done      = done_reg;
    assign status.trans_cnt = cnt_reg;
    assign status.min_rot   = best_reg;

endmodule

>>> sv/uniform_lbp_label_table.sv
// Channel   Direction  Word                   Handshake
// s_        in         ulbp_pkg::in_word_t    s_valid / s_ready
// m_        out        ulbp_pkg::out_word_t   m_valid / m_ready
// cfg_      in         index and data         cfg_wr_en, no wait
//
// m_valid rises after a lookup is accepted, once the registered read of the label memory
// has passed through ST_LK and ST_RESP, which holds while an earlier result waits on
// m_ready; the next word can be accepted as m_valid rises. A build makes two passes over
// all 256 codes, running the 8-step rotate and compare unit on each code in each pass, and
// a copy state for each rotation whose label is copied from the memory.
// s_ready is high only while the sequencer is idle; a result waiting on m_ready
// does not block acceptance, only the delivery of the next result.
// Reset clears the state, the flags and the null label and sets the transition limit to 8;
// the data registers are not reset, and the table holds nothing defined until the first build.
module uniform_lbp_label_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ulbp_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ulbp_pkg::out_word_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [ulbp_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ulbp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LK      = 4'd1;
    localparam logic [3:0] ST_RESP    = 4'd2;
    localparam logic [3:0] ST_B_START = 4'd3;
    localparam logic [3:0] ST_B_ROT   = 4'd4;
    localparam logic [3:0] ST_B_DEC   = 4'd5;
    localparam logic [3:0] ST_B_COPY  = 4'd6;
    localparam logic [3:0] ST_N_START = 4'd7;
    localparam logic [3:0] ST_N_ROT   = 4'd8;
    localparam logic [3:0] ST_N_DEC   = 4'd9;

    logic [3:0]                        state_reg, state_next;
    logic [ulbp_pkg::CODE_W-1:0]       code_reg, code_next;
    logic [ulbp_pkg::LABEL_W-1:0]      next_label_reg, next_label_next;
    logic [ulbp_pkg::LABEL_W-1:0]      null_reg, null_next;
    logic                              built_reg, built_next;
    logic [ulbp_pkg::LABEL_W-1:0]      res_label_reg, res_label_next;
    logic                              m_valid_reg, m_valid_next;
    ulbp_pkg::out_word_t               m_data_reg, m_data_next;
    logic [ulbp_pkg::CFG_DATA_W-1:0]   max_trans_reg;
    logic                              rot_inv_reg;

    logic [ulbp_pkg::LABEL_W-1:0]      label_mem [ulbp_pkg::TABLE_DEPTH];
    logic [ulbp_pkg::LABEL_W-1:0]      rdata_reg;
    logic                              mem_we;
    logic                              mem_re;
    logic [ulbp_pkg::CODE_W-1:0]       rd_addr;
    logic [ulbp_pkg::LABEL_W-1:0]      mem_wdata;

    logic                              unit_start;
    ulbp_pkg::rot_status_t             rot_st;
    logic                              uniform;
    logic                              last_code;
    logic                              s_fire;

    ulbp_rot_unit u_rot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .code_in (code_reg),
        .status  (rot_st)
    );

    assign uniform   = (rot_st.trans_cnt <= max_trans_reg);
    assign last_code = (code_reg == ulbp_pkg::CODE_LAST);
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_trans_reg <= 4'd8;
            rot_inv_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ulbp_pkg::REG_MAX_TRANSITIONS:    max_trans_reg <= cfg_wdata;
                ulbp_pkg::REG_ROTATION_INVARIANT: rot_inv_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            label_mem[code_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= label_mem[rd_addr];
        end
    end

    always_comb begin
        state_next      = state_reg;
        code_next       = code_reg;
        next_label_next = next_label_reg;
        null_next       = null_reg;
        built_next      = built_reg;
        res_label_next  = res_label_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        rd_addr         = s_data.code;
        mem_wdata       = next_label_reg;
        unit_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation == ulbp_pkg::OP_LOOKUP) begin
                        mem_re     = 1'b1;
                        state_next = ST_LK;
                    end else begin
                        code_next       = '0;
                        next_label_next = '0;
                        state_next      = ST_B_START;
                    end
                end
            end
            ST_LK: begin
                res_label_next = rdata_reg;
                state_next     = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.label       = res_label_reg;
                    m_data_next.null_label  = null_reg;
                    m_data_next.table_valid = built_reg;
                    state_next              = ST_IDLE;
                end
            end
            ST_B_START: begin
                unit_start = 1'b1;
                state_next = ST_B_ROT;
            end
            ST_B_ROT: begin
                if (rot_st.done) begin
                    state_next = ST_B_DEC;
                end
            end
            ST_B_DEC: begin
                if (uniform && rot_inv_reg && (rot_st.min_rot != code_reg)) begin
                    // A smaller rotation was labeled earlier; fetch its label.
                    rd_addr    = rot_st.min_rot;
                    mem_re     = 1'b1;
                    state_next = ST_B_COPY;
                end else begin
                    if (uniform) begin
                        mem_we          = 1'b1;
                        next_label_next = next_label_reg + 1'b1;
                    end
                    code_next  = code_reg + 1'b1;
                    state_next = last_code ? ST_N_START : ST_B_START;
                end
            end
            ST_B_COPY: begin
                mem_we     = 1'b1;
                mem_wdata  = rdata_reg;
                code_next  = code_reg + 1'b1;
                state_next = last_code ? ST_N_START : ST_B_START;
            end
            ST_N_START: begin
                null_next  = next_label_reg;
                unit_start = 1'b1;
                state_next = ST_N_ROT;
            end
            ST_N_ROT: begin
                if (rot_st.done) begin
                    state_next = ST_N_DEC;
                end
            end
            ST_N_DEC: begin
                mem_wdata = null_reg;
                mem_we    = !uniform;
                if (last_code) begin
                    built_next     = 1'b1;
                    res_label_next = null_reg;
                    state_next     = ST_RESP;
                end else begin
                    code_next  = code_reg + 1'b1;
                    state_next = ST_N_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            null_reg    <= '0;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            null_reg    <= null_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg       <= code_next;
        next_label_reg <= next_label_next;
        res_label_reg  <= res_label_next;
        m_data_reg     <= m_data_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !s_ready)
    else $error("label memory written while the block is idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_data.operation == ulbp_pkg::OP_LOOKUP)) |=> (state_reg == ST_LK))
    else $error("accepted lookup did not start a memory read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(built_reg))
    else $error("table valid flag dropped after a build");

    assert property (@(posedge aclk) disable iff (!aresetn)
        rot_st.done |-> ((state_reg == ST_B_ROT) || (state_reg == ST_N_ROT)))
    else $error("rotate unit finished outside a wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && (!m_valid_reg || m_ready)) |=> m_valid_reg)
    else $error("result not presented after the sequencer finished");

endmodule
